[sv/bdsgps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsgps_pkg
// Constants shared by the BDS day/time to GPS week/seconds converter and its
// checker.
// ----------------------------------------------------------------------------
package bdsgps_pkg;

  localparam int unsigned SEC_PER_DAY    = 86400;
  localparam int unsigned SEC_PER_WEEK   = 604800;
  localparam int unsigned HALF_DAY       = 43200;
  localparam int unsigned BDS_TO_GPS_SEC = 14;
  localparam int unsigned DAYS_PER_4YR   = 1461;
  localparam int unsigned MJD_OFFSET     = 678590;
  localparam int unsigned MJD_GPS_EPOCH  = 44244;
  // Whole weeks added so that the day count stays positive before the divide.
  localparam int unsigned WEEK_BIAS      = 131072;
  localparam int unsigned DAY_BIAS       = 7 * WEEK_BIAS - MJD_GPS_EPOCH - MJD_OFFSET;
  // Reciprocals for exact division of narrow unsigned values.
  localparam int unsigned RECIP_100      = 5243;     // x / 100 = (x * R) >> 19
  localparam int unsigned RECIP_100_SH   = 19;
  localparam int unsigned RECIP_7        = 2396746;  // x / 7 = (x * R) >> 24
  localparam int unsigned RECIP_7_SH     = 24;
  localparam int unsigned PIPE_DEPTH     = 6;

  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  function automatic logic [19:0] dow_seconds(input logic [2:0] dow);
    logic [19:0] s;
    case (dow)
      3'd0:    s = 20'd0;
      3'd1:    s = 20'd86400;
      3'd2:    s = 20'd172800;
      3'd3:    s = 20'd259200;
      3'd4:    s = 20'd345600;
      3'd5:    s = 20'd432000;
      3'd6:    s = 20'd518400;
      default: s = 20'd0;
    endcase
    return s;
  endfunction

endpackage

[sv/bds_day_time_to_gps_week_seconds.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_day_time_to_gps_week_seconds
// Converts a BDS header epoch and a data time of day to GPS week and seconds.
// ----------------------------------------------------------------------------
// The block takes one beat per clock and never raises busy. Every beat gives
// one result beat, marked by out_valid, after it has passed the six register
// stages (leap-year reciprocal, rollover, year multiply, day sum, divide by
// seven, week split). Results leave in the order the beats came in, and the
// receiver must take each one in the cycle it is shown.
module bds_day_time_to_gps_week_seconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_header_year,
  input  logic [8:0]  in_header_day,
  input  logic [16:0] in_header_second,
  input  logic [16:0] in_data_second,
  output logic        out_valid,
  output logic [12:0] out_gps_week,
  output logic [19:0] out_seconds_of_week,
  output logic [11:0] out_data_year,
  output logic [8:0]  out_data_day
);
  import bdsgps_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;

  logic [24:0]        q100_prod;
  logic [17:0]        ds_half;
  logic [17:0]        hs_half;
  logic signed [10:0] dday1;

  logic [11:0]        s1_hy_r;
  logic [5:0]         s1_q100_r;
  logic signed [10:0] s1_dday_r;
  logic [16:0]        s1_ds_r;

  logic [12:0]        hund;
  logic               div100;
  logic               leap;
  logic [8:0]         maxday;
  logic [17:0]        sec14;
  logic               carry;

  logic [12:0]        s2_dyear_r;
  logic signed [10:0] s2_dday_r;
  logic [16:0]        s2_secs_r;
  logic               s2_carry_r;

  logic signed [13:0] ym1;
  logic signed [23:0] ym1_ext;

  logic signed [23:0] s3_prod_r;
  logic [12:0]        s3_dyear_r;
  logic signed [10:0] s3_dday_r;
  logic [16:0]        s3_secs_r;
  logic               s3_carry_r;

  logic signed [23:0] day_sum;

  logic [20:0]        s4_u_r;
  logic [12:0]        s4_dyear_r;
  logic signed [10:0] s4_dday_r;
  logic [16:0]        s4_secs_r;

  logic [42:0]        q7_prod;

  logic [17:0]        s5_q_r;
  logic [2:0]         s5_ulo_r;
  logic [12:0]        s5_dyear_r;
  logic signed [10:0] s5_dday_r;
  logic [16:0]        s5_secs_r;

  logic [2:0]         q7_lo;
  logic [2:0]         dow;

  assign busy = 1'b0;

  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

  // Stage 1: day shift against the header and year / 100.
  assign q100_prod = 25'(in_header_year) * 25'(RECIP_100);
  assign ds_half   = 18'(in_data_second) + 18'(HALF_DAY);
  assign hs_half   = 18'(in_header_second) + 18'(HALF_DAY);

  always_comb begin
    dday1 = $signed({2'b00, in_header_day});
    if (18'(in_header_second) > ds_half) begin
      dday1 = $signed({2'b00, in_header_day}) + 11'sd1;
    end else if (18'(in_data_second) > hs_half) begin
      dday1 = $signed({2'b00, in_header_day}) - 11'sd1;
    end
  end

  always_ff @(posedge clk) begin
    s1_hy_r   <= in_header_year;
    s1_q100_r <= q100_prod[RECIP_100_SH +: 6];
    s1_dday_r <= dday1;
    s1_ds_r   <= in_data_second;
  end

  // Stage 2: Gregorian leap rule, year rollover and second-of-day carry.
  assign hund   = 13'(s1_q100_r) * 13'd100;
  assign div100 = (13'(s1_hy_r) == hund);
  assign leap   = ((s1_hy_r[1:0] == 2'b00) && !div100) ||
                  (div100 && (s1_q100_r[1:0] == 2'b00));
  assign maxday = leap ? DAYS_LEAP : DAYS_COMMON;
  assign sec14  = 18'(s1_ds_r) + 18'(BDS_TO_GPS_SEC);
  assign carry  = (sec14 >= 18'(SEC_PER_DAY));

  always_ff @(posedge clk) begin
    if (s1_dday_r > $signed({2'b00, maxday})) begin
      s2_dyear_r <= 13'(s1_hy_r) + 13'd1;
      s2_dday_r  <= 11'sd1;
    end else begin
      s2_dyear_r <= 13'(s1_hy_r);
      s2_dday_r  <= s1_dday_r;
    end
    s2_secs_r  <= carry ? 17'(sec14 - 18'(SEC_PER_DAY)) : 17'(sec14);
    s2_carry_r <= carry;
  end

  // Stage 3: days before the year, times four.
  assign ym1     = $signed({1'b0, s2_dyear_r}) - 14'sd1;
  assign ym1_ext = 24'(ym1);

  always_ff @(posedge clk) begin
    s3_prod_r  <= ym1_ext * 24'sd1461;
    s3_dyear_r <= s2_dyear_r;
    s3_dday_r  <= s2_dday_r;
    s3_secs_r  <= s2_secs_r;
    s3_carry_r <= s2_carry_r;
  end

  // Stage 4: biased day count since the GPS epoch.
  assign day_sum = (s3_prod_r >>> 2) + 24'(s3_dday_r) - 24'sd1 +
                   $signed({23'd0, s3_carry_r}) + $signed(24'(DAY_BIAS));

  always_ff @(posedge clk) begin
    s4_u_r     <= day_sum[20:0];
    s4_dyear_r <= s3_dyear_r;
    s4_dday_r  <= s3_dday_r;
    s4_secs_r  <= s3_secs_r;
  end

  // Stage 5: divide by seven.
  assign q7_prod = 43'(s4_u_r) * 43'(RECIP_7);

  always_ff @(posedge clk) begin
    s5_q_r     <= q7_prod[RECIP_7_SH +: 18];
    s5_ulo_r   <= s4_u_r[2:0];
    s5_dyear_r <= s4_dyear_r;
    s5_dday_r  <= s4_dday_r;
    s5_secs_r  <= s4_secs_r;
  end

  // Stage 6: week number and seconds of week.
  assign q7_lo = 3'({s5_q_r[2:0], 3'b000} - {3'b000, s5_q_r[2:0]});
  assign dow   = s5_ulo_r - q7_lo;

  always_ff @(posedge clk) begin
    out_gps_week        <= s5_q_r[12:0];
    out_seconds_of_week <= dow_seconds(dow) + 20'(s5_secs_r);
    out_data_year       <= s5_dyear_r[11:0];
    out_data_day        <= s5_dday_r[8:0];
  end

endmodule

[sv/bdsgps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsgps_checker
// Port-level checks of the BDS to GPS converter, bound to its top level.
// ----------------------------------------------------------------------------
module bdsgps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [19:0] out_seconds_of_week
);
  import bdsgps_pkg::*;

  // Every accepted beat comes out as a result marked by out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted beat did not produce a result");

  // No result appears without an accepted beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##6 !out_valid)
    else $error("result without an accepted beat");

  // Seconds of week stay inside one week.
  a_sow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seconds_of_week < 20'(SEC_PER_WEEK)))
    else $error("seconds of week out of range");

  // The pipeline never holds off the sender.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind bds_day_time_to_gps_week_seconds bdsgps_checker u_bdsgps_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_seconds_of_week (out_seconds_of_week)
);
